>>> sv/ryc_pkg.sv
// Shared types, constants and the Q16 clamp function for the RGB to YCbCr 4:2:0 converter.
package ryc_pkg;

  // Field widths and reset values
  localparam int RYC_PIX_W      = 8;
  localparam int RYC_LW_W       = 11;
  localparam int RYC_BLK_W      = 9;
  localparam int RYC_MAX_WIDTH  = 1024;
  localparam int RYC_QUEUE_DEPTH = 4;
  localparam logic [RYC_LW_W-1:0] RYC_LW_RESET = 11'd352;

  // Q16 arithmetic: sums are exact and fit 26 signed bits
  localparam int RYC_SUM_W  = 26;
  localparam int RYC_FRAC_W = 16;
  localparam int RYC_PAIR_W = 9;

  localparam logic signed [RYC_SUM_W-1:0] RYC_KY_R  = 26'sd19595;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KY_G  = 26'sd38470;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KY_B  = 26'sd7471;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KCB_R = 26'sd11076;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KCB_G = 26'sd21692;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KCB_B = 26'sd32768;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KCR_R = 26'sd32768;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KCR_G = 26'sd27460;
  localparam logic signed [RYC_SUM_W-1:0] RYC_KCR_B = 26'sd5328;
  localparam logic signed [RYC_SUM_W-1:0] RYC_OFFSET = 26'sd8388608;

  // What the back end does with a pixel's chroma
  typedef enum logic [1:0] {
    KIND_LEFT,   // even column: hold chroma for the pair
    KIND_PAIR,   // odd column, even row: store the pair sum
    KIND_AVG     // odd column, odd row: give the 2x2 mean
  } ryc_kind_t;

  typedef struct packed {
    logic [RYC_PIX_W-1:0] red;
    logic [RYC_PIX_W-1:0] green;
    logic [RYC_PIX_W-1:0] blue;
    ryc_kind_t            kind;
  } ryc_pix_t;

  // Truncate a nonnegative Q16 value to an integer and clamp to 0..255
  function automatic logic [RYC_PIX_W-1:0] ryc_clamp(input logic signed [RYC_SUM_W-1:0] v);
    logic [RYC_PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v[RYC_SUM_W-1:RYC_FRAC_W] > (RYC_SUM_W-RYC_FRAC_W)'(255)) begin
      res = '1;
    end else begin
      res = v[RYC_FRAC_W+RYC_PIX_W-1:RYC_FRAC_W];
    end
    return res;
  endfunction

endpackage

>>> sv/ryc_channels.sv
// Valid/ready channel interfaces for pixels, results and the line width register.
interface ryc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface ryc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] cb_avg;
  logic [7:0] cr_avg;
  logic [8:0] block_column;

  modport source (output valid, luma, chroma_valid, cb_avg, cr_avg, block_column,
                  input ready);
  modport sink   (input valid, luma, chroma_valid, cb_avg, cr_avg, block_column,
                  output ready);
endinterface

interface ryc_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] line_width;

  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

>>> sv/ryc_front.sv
// Front end: line width register, column and row tracking, chroma classification.
module ryc_front #(
  parameter int MAX_WIDTH = ryc_pkg::RYC_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ryc_pixel_if.sink                    in_ch,
  ryc_cfg_if.sink                      cfg_ch,
  output logic                         push_valid,
  input  logic                         push_ready,
  output ryc_pkg::ryc_pix_t            push_pix,
  output logic [((MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1)-1:0] push_idx
);
  import ryc_pkg::*;

  localparam int IDX_W = (MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1;
  localparam int CNT_W = $clog2(MAX_WIDTH) > 2 ? $clog2(MAX_WIDTH) : 2;
  localparam int EW    = (CNT_W + 1) > RYC_LW_W ? CNT_W + 1 : RYC_LW_W;
  localparam int MAXW  = (MAX_WIDTH / 2) * 2;

  logic [RYC_LW_W-1:0] line_width_r;
  logic [CNT_W-1:0]    col_r, col_use, col_nxt;
  logic                odd_r, odd_use, odd_nxt;
  logic [EW-1:0]       eff_w, col_inc;
  logic                accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push_valid   = in_ch.valid;
  assign accept       = in_ch.valid && push_ready;

  // Clear position at frame start, classify, and advance the column
  always_comb begin
    col_use = in_ch.frame_start ? '0 : col_r;
    odd_use = in_ch.frame_start ? 1'b0 : odd_r;

    eff_w = EW'({line_width_r[RYC_LW_W-1:1], 1'b0});
    if (eff_w < EW'(2)) begin
      eff_w = EW'(2);
    end
    if (eff_w > EW'(MAXW)) begin
      eff_w = EW'(MAXW);
    end

    col_inc = EW'(col_use) + EW'(1);
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      odd_nxt = ~odd_use;
    end else begin
      col_nxt = col_use + CNT_W'(1);
      odd_nxt = odd_use;
    end

    push_pix.red   = in_ch.red;
    push_pix.green = in_ch.green;
    push_pix.blue  = in_ch.blue;
    if (!col_use[0]) begin
      push_pix.kind = KIND_LEFT;
    end else if (odd_use) begin
      push_pix.kind = KIND_AVG;
    end else begin
      push_pix.kind = KIND_PAIR;
    end
    push_idx = IDX_W'(col_use >> 1);
  end

  // Hold the line width and the raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= RYC_LW_RESET;
      col_r        <= '0;
      odd_r        <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        line_width_r <= cfg_ch.line_width;
      end
      if (accept) begin
        col_r <= col_nxt;
        odd_r <= odd_nxt;
      end
    end
  end

endmodule

>>> sv/ryc_queue.sv
// Small request queue between the front end and the back end.
module ryc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ryc_pkg::RYC_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import ryc_pkg::*;

  localparam int PTR_W = DEPTH > 2 ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/ryc_back.sv
// Back end: colour conversion, half-line pair store, chroma mean and output register.
module ryc_back #(
  parameter int MAX_WIDTH = ryc_pkg::RYC_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  output logic                         head_ready,
  input  ryc_pkg::ryc_pix_t            head_pix,
  input  logic [((MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1)-1:0] head_idx,
  ryc_result_if.source                 out_ch
);
  import ryc_pkg::*;

  localparam int HALF_DEPTH = (MAX_WIDTH/2) > 1 ? MAX_WIDTH/2 : 1;
  localparam int IDX_W      = (MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1;
  localparam int TOT_W      = RYC_PAIR_W + 1;

  // Stage 1: Q16 sums
  logic                        s1_v_r;
  ryc_kind_t                   s1_kind_r;
  logic [IDX_W-1:0]            s1_idx_r;
  logic signed [RYC_SUM_W-1:0] s1_y_r, s1_cb_r, s1_cr_r;
  // Stage 2: clamped components and the stored pair sum
  logic                        s2_v_r;
  ryc_kind_t                   s2_kind_r;
  logic [IDX_W-1:0]            s2_idx_r;
  logic [RYC_PIX_W-1:0]        s2_y_r, s2_cb_r, s2_cr_r;
  logic [2*RYC_PAIR_W-1:0]     pair_rd_r;
  // Output stage
  logic                        out_v_r;
  logic [RYC_PIX_W-1:0]        luma_r, cb_avg_r, cr_avg_r;
  logic                        chroma_valid_r;
  logic [RYC_BLK_W-1:0]        block_column_r;
  logic [RYC_PIX_W-1:0]        left_cb_r, left_cr_r;

  logic [2*RYC_PAIR_W-1:0]     pair_mem [HALF_DEPTH];

  logic signed [RYC_SUM_W-1:0] r_s, g_s, b_s, y_sum, cb_sum, cr_sum;
  logic                        out_free, s2_move, s2_free, s1_move, s1_free, pop;
  logic                        pair_we;
  logic [RYC_PAIR_W-1:0]       pair_cb, pair_cr;
  logic [TOT_W-1:0]            cb_tot, cr_tot;
  logic [RYC_PIX_W-1:0]        cb_avg_nxt, cr_avg_nxt;
  logic                        chroma_valid_nxt;

  // Stall chain from the output register back to the queue
  assign out_free   = !out_v_r || out_ch.ready;
  assign s2_move    = s2_v_r && out_free;
  assign s2_free    = !s2_v_r || s2_move;
  assign s1_move    = s1_v_r && s2_free;
  assign s1_free    = !s1_v_r || s1_move;
  assign head_ready = s1_free;
  assign pop        = head_valid && s1_free;

  // Weighted sums in Q16
  always_comb begin
    r_s = $signed({{(RYC_SUM_W-RYC_PIX_W){1'b0}}, head_pix.red});
    g_s = $signed({{(RYC_SUM_W-RYC_PIX_W){1'b0}}, head_pix.green});
    b_s = $signed({{(RYC_SUM_W-RYC_PIX_W){1'b0}}, head_pix.blue});
    y_sum  = RYC_KY_R * r_s + RYC_KY_G * g_s + RYC_KY_B * b_s;
    cb_sum = RYC_OFFSET - RYC_KCB_R * r_s - RYC_KCB_G * g_s + RYC_KCB_B * b_s;
    cr_sum = RYC_OFFSET + RYC_KCR_R * r_s - RYC_KCR_G * g_s - RYC_KCR_B * b_s;
  end

  // Pair sums, 2x2 means and the action for this pixel
  always_comb begin
    pair_cb = RYC_PAIR_W'(left_cb_r) + RYC_PAIR_W'(s2_cb_r);
    pair_cr = RYC_PAIR_W'(left_cr_r) + RYC_PAIR_W'(s2_cr_r);
    cb_tot  = TOT_W'(pair_rd_r[RYC_PAIR_W-1:0]) + TOT_W'(pair_cb);
    cr_tot  = TOT_W'(pair_rd_r[2*RYC_PAIR_W-1:RYC_PAIR_W]) + TOT_W'(pair_cr);
    pair_we          = 1'b0;
    chroma_valid_nxt = 1'b0;
    cb_avg_nxt       = '0;
    cr_avg_nxt       = '0;
    case (s2_kind_r)
      KIND_LEFT: begin
        pair_we = 1'b0;
      end
      KIND_PAIR: begin
        pair_we = s2_move;
      end
      KIND_AVG: begin
        chroma_valid_nxt = 1'b1;
        cb_avg_nxt       = cb_tot[TOT_W-1:2];
        cr_avg_nxt       = cr_tot[TOT_W-1:2];
      end
      default: begin
        pair_we = 1'b0;
      end
    endcase
  end

  // Half-line store: write pair sums, read ahead for the odd row
  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[s2_idx_r] <= {pair_cr, pair_cb};
    end
    if (s1_move) begin
      pair_rd_r <= pair_mem[s1_idx_r];
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind_r <= head_pix.kind;
      s1_idx_r  <= head_idx;
      s1_y_r    <= y_sum;
      s1_cb_r   <= cb_sum;
      s1_cr_r   <= cr_sum;
    end
    if (s1_move) begin
      s2_kind_r <= s1_kind_r;
      s2_idx_r  <= s1_idx_r;
      s2_y_r    <= ryc_clamp(s1_y_r);
      s2_cb_r   <= ryc_clamp(s1_cb_r);
      s2_cr_r   <= ryc_clamp(s1_cr_r);
    end
    if (s2_move) begin
      luma_r         <= s2_y_r;
      chroma_valid_r <= chroma_valid_nxt;
      cb_avg_r       <= cb_avg_nxt;
      cr_avg_r       <= cr_avg_nxt;
      block_column_r <= RYC_BLK_W'(s2_idx_r);
    end
  end

  // Valid flags and left-column chroma
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      left_cb_r <= '0;
      left_cr_r <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= head_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      if (s2_move && s2_kind_r == KIND_LEFT) begin
        left_cb_r <= s2_cb_r;
        left_cr_r <= s2_cr_r;
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.luma         = luma_r;
  assign out_ch.chroma_valid = chroma_valid_r;
  assign out_ch.cb_avg       = cb_avg_r;
  assign out_ch.cr_avg       = cr_avg_r;
  assign out_ch.block_column = block_column_r;

endmodule

>>> sv/rgb_to_ycbcr420_converter_core.sv
// A result passes the queue, the sum stage, the clamp stage and the output register.
// Throughput: one pixel per cycle while the output is not stalled; the multiply-add stage
// and the pair store (one write and one read port) each handle one pixel a cycle.
// The 4-entry queue lets a steady input keep flowing during an output stall until it fills.
// Reset (rst_n low, synchronous) clears position, valids and line width to 352;
// the pair store holds no reset and is filled by even rows before odd rows read it.
module rgb_to_ycbcr420_converter_core #(
  parameter int MAX_WIDTH = ryc_pkg::RYC_MAX_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  ryc_pixel_if.sink      in_ch,
  ryc_result_if.source   out_ch,
  ryc_cfg_if.sink        cfg_ch
);
  import ryc_pkg::*;

  localparam int IDX_W = (MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1;
  localparam int Q_W   = $bits(ryc_pix_t) + IDX_W;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  ryc_pix_t         push_pix, pop_pix;
  logic [IDX_W-1:0] push_idx, pop_idx;
  logic [Q_W-1:0]   pop_data;

  ryc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pix   (push_pix),
    .push_idx   (push_idx)
  );

  ryc_queue #(.W(Q_W), .DEPTH(RYC_QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_idx, push_pix}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_idx, pop_pix} = pop_data;

  ryc_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (pop_valid),
    .head_ready (pop_ready),
    .head_pix   (pop_pix),
    .head_idx   (pop_idx),
    .out_ch     (out_ch)
  );

endmodule

>>> sv/ryc_checker.sv
// Port-level checks on the converter, bound to the top level.
module ryc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] luma,
  input logic       chroma_valid,
  input logic [7:0] cb_avg,
  input logic [7:0] cr_avg,
  input logic [8:0] block_column,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  logic [3:0] pending_r;
  logic       last_chroma_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track requests in flight and the chroma flag of the last result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= '0;
      last_chroma_r <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        pending_r <= pending_r + 4'd1;
      end else if (out_acc && !in_acc) begin
        pending_r <= pending_r - 4'd1;
      end
      if (out_acc) begin
        last_chroma_r <= chroma_valid;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(luma) && $stable(chroma_valid)
      && $stable(cb_avg) && $stable(cr_avg) && $stable(block_column))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result shown with no request in flight");

  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !chroma_valid |-> cb_avg == 8'd0 && cr_avg == 8'd0)
    else $error("chroma means not zero on a pixel without a block");

  a_chroma_alt: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && chroma_valid |-> !last_chroma_r)
    else $error("two chroma blocks on consecutive pixels");

  a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("line width write refused");

endmodule

bind rgb_to_ycbcr420_converter_core ryc_checker u_ryc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .luma         (out_ch.luma),
  .chroma_valid (out_ch.chroma_valid),
  .cb_avg       (out_ch.cb_avg),
  .cr_avg       (out_ch.cr_avg),
  .block_column (out_ch.block_column),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready)
);
